@@ rtl/core/peu_pkg.sv @@
package peu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DT_W      = 20;
	localparam int SOL_W     = 24;
	localparam int REG_W     = 32;
	localparam int IDX_W     = 3;

	localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	localparam logic [IDX_W-1:0] REG_DELTA_TIME     = 3'd0;
	localparam logic [IDX_W-1:0] REG_GRAVITY_X      = 3'd1;
	localparam logic [IDX_W-1:0] REG_GRAVITY_Y      = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_COLOR    = 3'd3;
	localparam logic [IDX_W-1:0] REG_END_COLOR      = 3'd4;
	localparam logic [IDX_W-1:0] REG_SIZE_OVER_LIFE = 3'd5;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] angle;
		logic signed [31:0] spin;
		logic signed [31:0] life_left;
		logic [30:0]        life_total;
		logic [30:0]        particle_size;
		logic               alive_in;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_angle;
		logic signed [31:0] new_life;
		logic [30:0]        new_size;
		logic [31:0]        rgba;
		logic               alive_out;
	} out_word_t;

	typedef struct packed {
		logic [DT_W-1:0]    delta_time;
		logic signed [31:0] gravity_x;
		logic signed [31:0] gravity_y;
		logic [31:0]        start_color;
		logic [31:0]        end_color;
		logic [SOL_W-1:0]   size_over_life;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] angle;
		logic signed [31:0] life;
		logic [30:0]        total;
		logic [30:0]        size;
		logic               alive;
		logic               skip;
	} mot_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/peu_motion.sv @@
module peu_motion (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  peu_pkg::in_word_t in_data,
	input  peu_pkg::cfg_t    cfg,
	output logic             mot_valid,
	output peu_pkg::mot_t    mot
);
	import peu_pkg::*;

	localparam int PW = 33 + DT_W + 1;

	logic signed [DT_W:0]  dts;
	logic signed [31:0]    dt32;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	in_word_t r_s1, r_s2, r_s3, r_s4;
	logic skip_s1, skip_s2, skip_s3, skip_s4;
	logic signed [32:0] ax_s1, ay_s1;
	logic signed [31:0] life_s1, life_s2, life_s3, life_s4;
	logic signed [PW-1:0] pvx_s2, pvy_s2, pan_s2;
	logic signed [31:0] vx_s3, vy_s3, ang_s3, vx_s4, vy_s4, ang_s4;
	logic signed [PW-1:0] ppx_s4, ppy_s4;
	mot_t mot_s5;

	assign dts  = signed'({1'b0, cfg.delta_time});
	assign dt32 = signed'({(32 - DT_W)'(0), cfg.delta_time});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= in_data;
			skip_s1 <= !in_data.alive_in || (in_data.life_left <= 0);
			ax_s1   <= 33'(in_data.acc_x) + 33'(cfg.gravity_x);
			ay_s1   <= 33'(in_data.acc_y) + 33'(cfg.gravity_y);
			life_s1 <= in_data.life_left - dt32;

			r_s2    <= r_s1;
			skip_s2 <= skip_s1;
			life_s2 <= life_s1;
			pvx_s2  <= PW'(ax_s1) * PW'(dts);
			pvy_s2  <= PW'(ay_s1) * PW'(dts);
			pan_s2  <= PW'(r_s1.spin) * PW'(dts);

			r_s3    <= r_s2;
			skip_s3 <= skip_s2;
			life_s3 <= life_s2;
			vx_s3   <= sat32(48'(r_s2.vel_x) + 48'(pvx_s2 >>> FRAC_BITS));
			vy_s3   <= sat32(48'(r_s2.vel_y) + 48'(pvy_s2 >>> FRAC_BITS));
			ang_s3  <= sat32(48'(r_s2.angle) + 48'(pan_s2 >>> FRAC_BITS));

			r_s4    <= r_s3;
			skip_s4 <= skip_s3;
			life_s4 <= life_s3;
			vx_s4   <= vx_s3;
			vy_s4   <= vy_s3;
			ang_s4  <= ang_s3;
			ppx_s4  <= PW'(vx_s3) * PW'(dts);
			ppy_s4  <= PW'(vy_s3) * PW'(dts);

			mot_s5.total <= r_s4.life_total;
			mot_s5.size  <= r_s4.particle_size;
			mot_s5.skip  <= skip_s4;
			if (skip_s4) begin
				mot_s5.pos_x <= r_s4.pos_x;
				mot_s5.pos_y <= r_s4.pos_y;
				mot_s5.vel_x <= r_s4.vel_x;
				mot_s5.vel_y <= r_s4.vel_y;
				mot_s5.angle <= r_s4.angle;
				mot_s5.life  <= r_s4.life_left;
				mot_s5.alive <= r_s4.alive_in;
			end else begin
				mot_s5.pos_x <= sat32(48'(r_s4.pos_x) + 48'(ppx_s4 >>> FRAC_BITS));
				mot_s5.pos_y <= sat32(48'(r_s4.pos_y) + 48'(ppy_s4 >>> FRAC_BITS));
				mot_s5.vel_x <= vx_s4;
				mot_s5.vel_y <= vy_s4;
				mot_s5.angle <= ang_s4;
				mot_s5.life  <= life_s4;
				mot_s5.alive <= life_s4 > 0;
			end
		end
	end

	assign mot_valid = v_s5;
	assign mot       = mot_s5;

endmodule

@@ rtl/core/peu_div.sv @@
module peu_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  peu_pkg::mot_t             mot_in,
	output logic                      div_valid,
	output logic [peu_pkg::FRAC_BITS:0] ratio,
	output peu_pkg::mot_t             mot_out
);
	import peu_pkg::*;

	logic                 fz0, fo0;
	logic [30:0]          rem0;

	logic [30:0]          rem_s  [FRAC_BITS];
	logic [FRAC_BITS-1:0] q_s    [FRAC_BITS];
	logic                 fz_s   [FRAC_BITS];
	logic                 fo_s   [FRAC_BITS];
	logic                 v_s    [FRAC_BITS];
	mot_t                 m_s    [FRAC_BITS];

	always_comb begin
		fz0  = !(mot_in.life > 0);
		fo0  = !fz0 && ((mot_in.total == 31'd0) || (mot_in.life[30:0] >= mot_in.total));
		rem0 = (fz0 || fo0) ? 31'd0 : mot_in.life[30:0];
	end

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
		logic [30:0]          prem;
		logic [FRAC_BITS-1:0] pq;
		logic                 pfz, pfo, pv;
		mot_t                 pm;
		logic [31:0]          trial;
		logic                 take;

		if (k == 0) begin : g_first
			assign prem = rem0;
			assign pq   = '0;
			assign pfz  = fz0;
			assign pfo  = fo0;
			assign pv   = in_valid;
			assign pm   = mot_in;
		end else begin : g_next
			assign prem = rem_s[k-1];
			assign pq   = q_s[k-1];
			assign pfz  = fz_s[k-1];
			assign pfo  = fo_s[k-1];
			assign pv   = v_s[k-1];
			assign pm   = m_s[k-1];
		end

		assign trial = {prem, 1'b0};
		assign take  = trial >= {1'b0, pm.total};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? 31'(trial - {1'b0, pm.total}) : trial[30:0];
				q_s[k]   <= {pq[FRAC_BITS-2:0], take};
				fz_s[k]  <= pfz;
				fo_s[k]  <= pfo;
				m_s[k]   <= pm;
			end
		end
	end

	always_comb begin
		priority if (fo_s[FRAC_BITS-1]) begin
			ratio = ONE_FX;
		end else if (fz_s[FRAC_BITS-1]) begin
			ratio = '0;
		end else begin
			ratio = {1'b0, q_s[FRAC_BITS-1]};
		end
	end

	assign div_valid = v_s[FRAC_BITS-1];
	assign mot_out   = m_s[FRAC_BITS-1];

endmodule

@@ rtl/core/peu_shade.sv @@
module peu_shade (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [peu_pkg::FRAC_BITS:0] ratio,
	input  peu_pkg::mot_t               mot,
	input  peu_pkg::cfg_t               cfg,
	output logic                        out_valid,
	output peu_pkg::out_word_t          out_data
);
	import peu_pkg::*;

	localparam int CW = FRAC_BITS + 11;
	localparam int FW = SOL_W + FRAC_BITS + 3;
	localparam int MW = SOL_W + 1;
	localparam int SW = 31 + MW;

	logic signed [CW-1:0] cnext [4];
	logic signed [CW-1:0] cacc_s1 [4];
	logic signed [SOL_W:0] solm;
	logic [FRAC_BITS:0]   inv;
	logic signed [FW-1:0] fprod_s1;
	logic v_s1, v_s2, v_s3;
	mot_t m_s1, m_s2;
	logic [31:0] rgba_n, rgba_s2;
	logic signed [FW:0] msum;
	logic [MW-1:0] mval;
	logic [SW-1:0] sprod_s2;
	logic [SW-FRAC_BITS-1:0] ns;
	logic [30:0] nsize;
	logic szen_s2;
	out_word_t o_s3;

	always_comb begin
		logic signed [8:0]  diff;
		logic signed [CW-1:0] c;
		for (int ch = 0; ch < 4; ch++) begin
			diff = signed'({1'b0, cfg.start_color[8*ch +: 8]}) -
			       signed'({1'b0, cfg.end_color[8*ch +: 8]});
			cnext[ch] = CW'(diff) * CW'(signed'({1'b0, ratio})) +
			            CW'(signed'({1'b0, cfg.end_color[8*ch +: 8], FRAC_BITS'(0)}));
		end
		for (int ch = 0; ch < 4; ch++) begin
			c = cacc_s1[ch] >>> FRAC_BITS;
			if (c < 0) begin
				rgba_n[8*ch +: 8] = 8'd0;
			end else if (c > 255) begin
				rgba_n[8*ch +: 8] = 8'd255;
			end else begin
				rgba_n[8*ch +: 8] = c[7:0];
			end
		end
	end

	assign solm = signed'({1'b0, cfg.size_over_life}) - (SOL_W + 1)'(ONE_FX);
	assign inv  = ONE_FX - ratio;
	assign msum = (FW + 1)'(fprod_s1 >>> FRAC_BITS) + (FW + 1)'(signed'({1'b0, ONE_FX}));
	assign mval = (msum < 0) ? '0 : msum[MW-1:0];
	assign ns    = sprod_s2[SW-1:FRAC_BITS];
	assign nsize = (ns > (SW - FRAC_BITS)'(31'h7fffffff)) ? 31'h7fffffff : ns[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 4; ch++) begin
				cacc_s1[ch] <= cnext[ch];
			end
			fprod_s1 <= FW'(solm) * FW'(signed'({1'b0, inv}));
			m_s1     <= mot;

			m_s2     <= m_s1;
			rgba_s2  <= rgba_n;
			sprod_s2 <= SW'(m_s1.size) * SW'(mval);
			szen_s2  <= cfg.size_over_life != SOL_W'(ONE_FX);

			o_s3.new_pos_x <= m_s2.pos_x;
			o_s3.new_pos_y <= m_s2.pos_y;
			o_s3.new_vel_x <= m_s2.vel_x;
			o_s3.new_vel_y <= m_s2.vel_y;
			o_s3.new_angle <= m_s2.angle;
			o_s3.new_life  <= m_s2.life;
			o_s3.alive_out <= m_s2.alive;
			o_s3.rgba      <= m_s2.skip ? 32'd0 : rgba_s2;
			o_s3.new_size  <= (m_s2.skip || !szen_s2) ? m_s2.size : nsize;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = o_s3;

endmodule

@@ rtl/core/particle_euler_update.sv @@
// an accepted word passes the motion, ratio divider and color/size stages in turn
// throughput: one word per cycle while the output is not stalled, set by the
// 16-stage ratio divider and the 5 motion and 3 color/size stages, all advancing together
// a stall on a valid output word freezes every stage and holds the input stalled
// reset clears all valid bits and loads the register defaults
module particle_euler_update (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  peu_pkg::in_word_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output peu_pkg::out_word_t              out_data,
	input  logic                            cfg_we,
	input  logic [peu_pkg::IDX_W-1:0]       cfg_index,
	input  logic [peu_pkg::REG_W-1:0]       cfg_data
);
	import peu_pkg::*;

	cfg_t cfg_q;
	logic en;
	logic mot_valid, div_valid;
	mot_t mot, mot_d;
	logic [FRAC_BITS:0] ratio;

	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_time     <= DT_W'(1092);
			cfg_q.gravity_x      <= '0;
			cfg_q.gravity_y      <= '0;
			cfg_q.start_color    <= 32'hffffffff;
			cfg_q.end_color      <= '0;
			cfg_q.size_over_life <= SOL_W'(ONE_FX);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELTA_TIME:     cfg_q.delta_time     <= cfg_data[DT_W-1:0];
				REG_GRAVITY_X:      cfg_q.gravity_x      <= cfg_data;
				REG_GRAVITY_Y:      cfg_q.gravity_y      <= cfg_data;
				REG_START_COLOR:    cfg_q.start_color    <= cfg_data;
				REG_END_COLOR:      cfg_q.end_color      <= cfg_data;
				REG_SIZE_OVER_LIFE: cfg_q.size_over_life <= cfg_data[SOL_W-1:0];
				default: ;
			endcase
		end
	end

	peu_motion u_motion (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.mot_valid (mot_valid),
		.mot       (mot)
	);

	peu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mot_valid),
		.mot_in    (mot),
		.div_valid (div_valid),
		.ratio     (ratio),
		.mot_out   (mot_d)
	);

	peu_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.ratio     (ratio),
		.mot       (mot_d),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_skip_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.alive_out && (out_data.new_life <= 0) |-> out_data.rgba == 32'd0)
		else $error("live word with spent life carries a color");

	a_dt_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_DELTA_TIME) |=>
		cfg_q.delta_time == $past(cfg_data[DT_W-1:0]))
		else $error("delta_time write lost");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mot_d))
		else $error("pipeline moved under stall");
`endif

endmodule
